// ----- rtl/mmft_pkg.sv -----
package mmft_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        now_ms;
    logic               run_present;
    logic signed [15:0] run_level;
    logic               reset_present;
    logic signed [15:0] reset_level;
    logic signed [31:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_ms;
    logic               running;
    logic               prealert_beep;
    logic               alarm_beep;
  } out_item_t;

  // Input modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_TOGGLE = 2'd1;
  localparam logic [1:0] MODE_RESET  = 2'd2;
  localparam logic [1:0] MODE_SET    = 2'd3;

  // Timer kinds
  localparam logic [2:0] KIND_SW    = 3'd0;
  localparam logic [2:0] KIND_CD    = 3'd1;
  localparam logic [2:0] KIND_PSW   = 3'd2;
  localparam logic [2:0] KIND_PCD   = 3'd3;
  localparam logic [2:0] KIND_PERM  = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_KIND   = 3'd0;
  localparam logic [2:0] REG_CDSEC  = 3'd1;
  localparam logic [2:0] REG_PSTART = 3'd2;
  localparam logic [2:0] REG_PWIN   = 3'd3;
  localparam logic [2:0] REG_PSTEP  = 3'd4;
  localparam logic [2:0] REG_TSTEP  = 3'd5;

  localparam logic [31:0] PERM_WRAP = 32'd359999900;

  // Datapath commands
  typedef struct packed {
    logic load;      // capture item, compute delta
    logic scale;     // compute throttle factor
    logic div_start; // start serial divider
    logic div_sel;   // 0: prealert quotient, 1: timeup quotient
    logic div_q100;  // divide scaled delta by 100
    logic mul_w;     // delta * factor
    logic finish;    // update state
    logic capture;   // load the output register
  } mmft_cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_scale;
  } mmft_stat_t;

endpackage

// ----- rtl/mmft_div.sv -----
module mmft_div
  import mmft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic [32:0] quotient,
  output logic        done
);

  logic [32:0] rem;
  logic [32:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;

  assign trial = {rem[32:0], quo[32]} - {2'b0, divisor};

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        cnt  <= 6'd33;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[32]};
          quo <= {quo[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- rtl/mmft_datapath.sv -----
module mmft_datapath
  import mmft_pkg::*;
#(
  parameter int FULL_SCALE = 10000
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [28:0] cfg_data,
  input  in_item_t   item,
  input  mmft_cmd_t  cmd,
  output mmft_stat_t stat,
  output out_item_t  result
);

  localparam int THRESH = (2 * FULL_SCALE) / 20;
  // Reciprocals: exact floor(x / FULL_SCALE) for x below 2^22, floor(x / 100) for 32-bit x
  localparam logic [31:0] FACT_RECIP =
    32'(((64'd1 << 37) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));
  localparam logic [31:0] DIV100_RECIP = 32'd2748779070;

  logic [2:0]  kind;
  logic [15:0] cd_sec;
  logic [31:0] pstart;
  logic [19:0] pwin, pstep, tstep;
  logic        running_flag;
  logic [31:0] count_value, last_stamp;

  in_item_t    it;
  logic [6:0]  factor;
  logic [31:0] du;
  logic        run_on;
  logic [32:0] q_pre, q_tu;
  logic        pre_beep, alm_beep;

  logic        prop;
  logic [32:0] div_dvd, div_q;
  logic [31:0] div_dvs;
  logic        div_done;

  assign prop = (kind == KIND_PSW) || (kind == KIND_PCD);
  assign stat.need_scale = prop;
  assign stat.div_done = div_done;

  function automatic logic above(input logic signed [15:0] lvl);
    above = ($signed({{16{lvl[15]}}, lvl}) + 32'sd0 + FULL_SCALE) > THRESH;
  endfunction

  // Sign and magnitude for the divider
  logic signed [32:0] v_s, vts;
  logic [32:0] v_mag;
  assign v_s = {count_value[31], count_value};
  assign vts = v_s - $signed({13'd0, tstep});
  assign v_mag = vts[32] ? -vts : vts;

  always_comb begin
    if (!cmd.div_sel) begin
      div_dvd = {1'b0, count_value};
      div_dvs = {12'd0, pstep};
    end else begin
      div_dvd = v_mag;
      div_dvs = {12'd0, tstep};
    end
  end

  mmft_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(div_dvd), .divisor(div_dvs),
    .quotient(div_q), .done(div_done)
  );

  logic [16:0] mag;
  logic [31:0] scaled_lvl;
  assign mag = it.run_level[15] ? 17'(-$signed({it.run_level[15], it.run_level}))
                                 : {1'b0, it.run_level};
  assign scaled_lvl = 32'(mag) * 32'd100;

  // Throttle factor and scaled delta by reciprocal multiplication
  logic [63:0] fact_prod;
  logic [26:0] fact_q;
  logic [63:0] du_prod;
  logic [31:0] du_q100;
  assign fact_prod = 64'(scaled_lvl) * 64'(FACT_RECIP);
  assign fact_q = fact_prod[63:37];
  assign du_prod = 64'(du) * 64'(DIV100_RECIP);
  assign du_q100 = {6'd0, du_prod[63:38]};

  // Capture registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= '0; cd_sec <= '0; pstart <= '0;
      pwin <= '0; pstep <= '0; tstep <= '0;
      running_flag <= 1'b0; count_value <= '0; last_stamp <= '0;
      pre_beep <= 1'b0; alm_beep <= 1'b0;
      result <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_KIND:   kind   <= cfg_data[2:0];
          REG_CDSEC:  cd_sec <= cfg_data[15:0];
          REG_PSTART: pstart <= {3'd0, cfg_data};
          REG_PWIN:   pwin   <= cfg_data[19:0];
          REG_PSTEP:  pstep  <= cfg_data[19:0];
          REG_TSTEP:  tstep  <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        it <= item;
        run_on <= running_flag;
        du <= item.now_ms - last_stamp;
        // Start/stop by run level in plain kinds
        if (item.mode == MODE_TICK && item.run_present && !prop) begin
          if (above(item.run_level) != running_flag) begin
            run_on <= above(item.run_level);
            if (above(item.run_level)) du <= '0;
          end
        end
      end
      if (cmd.scale) begin
        if (!it.run_present) factor <= '0;
        else if (fact_q > 27'd100) factor <= 7'd100;
        else factor <= fact_q[6:0];
      end
      if (cmd.mul_w) du <= du * {25'd0, factor};
      if (cmd.div_q100) du <= du_q100;
      if (div_done) begin
        if (!cmd.div_sel) q_pre <= div_q;
        else q_tu <= div_q;
      end
      if (cmd.finish) begin
        logic [31:0] nc;
        logic signed [33:0] v, d, wp, wt;
        logic pb, ab;
        nc = count_value;
        pb = 1'b0;
        ab = 1'b0;
        v = {{2{count_value[31]}}, count_value};
        d = {{2{du[31]}}, du};
        wp = $signed({1'b0, q_pre}) * $signed({14'd0, pstep});
        wt = (vts[32] ? -$signed({1'b0, q_tu}) : $signed({1'b0, q_tu}))
             * $signed({14'd0, tstep});
        case (it.mode)
          MODE_TICK: begin
            if (run_on) begin
              if (kind == KIND_PERM) begin
                nc = count_value + du;
                if (!nc[31] && nc >= PERM_WRAP) nc = '0;
                pstart <= nc;
              end else if (kind == KIND_SW || kind == KIND_PSW) begin
                nc = count_value + du;
              end else begin
                if (pwin != 0 && pstep != 0 && v > $signed({14'd0, pstep})
                    && v < $signed({14'd0, pwin}) + 34'sd1000
                    && v > wp && v - d <= wp)
                  pb = 1'b1;
                if (v < 0 && tstep != 0 && v > wt && v - d <= wt)
                  ab = 1'b1;
                if (v >= 0 && v < d) ab = 1'b1;
                nc = count_value - du;
              end
              last_stamp <= it.now_ms;
            end
            running_flag <= run_on;
            count_value <= nc;
            if (it.reset_present && above(it.reset_level)) begin
              running_flag <= prop;
              if (prop) last_stamp <= it.now_ms;
              if (kind == KIND_SW || kind == KIND_PSW) count_value <= '0;
              else if (prop || kind == KIND_CD) count_value <= cd_sec * 32'd1000;
              else if (kind == KIND_PERM)
                count_value <= (run_on) ? nc : pstart;
            end
          end
          MODE_TOGGLE: begin
            if (!prop) begin
              running_flag <= !running_flag;
              if (!running_flag) last_stamp <= it.now_ms;
            end
          end
          MODE_RESET: begin
            running_flag <= prop;
            if (prop) last_stamp <= it.now_ms;
            if (kind == KIND_SW || kind == KIND_PSW) count_value <= '0;
            else if (prop || kind == KIND_CD) count_value <= cd_sec * 32'd1000;
            else if (kind == KIND_PERM) count_value <= pstart;
          end
          default: begin
            if (kind == KIND_PERM) count_value <= it.new_value;
          end
        endcase
        pre_beep <= pb;
        alm_beep <= ab;
      end
      // Load the output register after finish
      if (cmd.capture) begin
        result.value_ms <= count_value;
        result.running <= running_flag;
        result.prealert_beep <= pre_beep;
        result.alarm_beep <= alm_beep;
      end
    end
  end

endmodule

// ----- rtl/mmft_ctrl.sv -----
module mmft_ctrl
  import mmft_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  mmft_stat_t stat,
  output mmft_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCL  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_D100 = 3'd3;
  localparam logic [2:0] S_DPRE = 3'd4;
  localparam logic [2:0] S_DTU  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_PUT  = 3'd7;

  logic [2:0] state, state_next;
  logic       started, started_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    started_next = started;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_SCL;
        started_next = 1'b0;
      end
      S_SCL: begin
        cmd.scale = 1'b1;
        state_next = stat.need_scale ? S_MUL : S_DPRE;
      end
      S_MUL: begin
        cmd.mul_w = 1'b1;
        state_next = S_D100;
      end
      S_D100: begin
        cmd.div_q100 = 1'b1;
        state_next = S_DPRE;
      end
      S_DPRE: begin
        cmd.div_sel = 1'b0;
        if (!started) begin
          cmd.div_start = 1'b1;
          started_next = 1'b1;
        end
        if (stat.div_done) begin
          state_next = S_DTU;
          started_next = 1'b0;
        end
      end
      S_DTU: begin
        cmd.div_sel = 1'b1;
        if (!started) begin
          cmd.div_start = 1'b1;
          started_next = 1'b1;
        end
        if (stat.div_done) begin
          state_next = S_FIN;
          started_next = 1'b0;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_PUT;
      end
      // Hold until the output register is free
      S_PUT: if (!out_valid || out_ready) begin
        cmd.capture = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state; track the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      started <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      started <= started_next;
      if (cmd.capture) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/multi_mode_flight_timer.sv -----
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | in_item_t
// out     | output    | out_valid/out_ready | out_item_t
// cfg     | input     | cfg_we              | cfg_idx, cfg_data
// Each item makes two 33-step passes through the serial divider, for the
// prealert and time-up quotients; the proportional kinds first also pass
// through the multiply and divide-by-100 states. The next item is accepted
// only after this one's result is loaded. Reset is synchronous and active
// high; it clears the configuration, the timer state and the controller. A
// result waits in the output register while the next item is processed;
// that item stalls only before its own result is loaded, if the old one is not taken.
module multi_mode_flight_timer
  import mmft_pkg::*;
#(
  parameter int CHANNEL_FULL_SCALE = 10000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [28:0] cfg_data
);

  mmft_cmd_t  cmd;
  mmft_stat_t stat;

  mmft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  mmft_datapath #(.FULL_SCALE(CHANNEL_FULL_SCALE)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .item(in_item), .cmd(cmd), .stat(stat),
    .result(out_item)
  );

endmodule

// ----- test/multi_mode_flight_timer_tb.sv -----
`timescale 1ns / 1ps

module multi_mode_flight_timer_tb;
  import mmft_pkg::*;

  localparam int FULL_SCALE  = 10000;
  localparam int N_ITEMS     = 1750;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = REG_KIND;
  logic [28:0] cfg_data = '0;

  multi_mode_flight_timer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Timer shadow: configuration and state
  logic [2:0]  sh_kind;
  logic [15:0] sh_cd_sec;
  logic [31:0] sh_perm_start;
  logic [19:0] sh_pre_win, sh_pre_step, sh_up_step;
  logic        sh_running;
  logic [31:0] sh_count, sh_stamp;

  out_item_t timer_results[$];
  int        mismatches = 0;
  int        sent = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;
  bit        hold_out = 1'b0;
  logic [31:0] clock_ms = '0;

  function automatic bit is_prop_kind();
    return sh_kind == KIND_PSW || sh_kind == KIND_PCD;
  endfunction

  function automatic bit over_threshold(logic signed [15:0] lvl);
    return (int'(lvl) + FULL_SCALE) > (2 * FULL_SCALE) / 20;
  endfunction

  function automatic void apply_timer_reset(logic [31:0] now);
    if (is_prop_kind()) begin
      sh_running = 1'b1;
      sh_stamp = now;
    end else begin
      sh_running = 1'b0;
    end
    case (sh_kind)
      KIND_SW, KIND_PSW: sh_count = '0;
      KIND_CD, KIND_PCD: sh_count = 32'(sh_cd_sec) * 32'd1000;
      KIND_PERM: sh_count = sh_perm_start;
      default: ;
    endcase
  endfunction

  function automatic void write_shadow_reg(logic [2:0] idx, logic [28:0] val);
    case (idx)
      REG_KIND:   sh_kind = val[2:0];
      REG_CDSEC:  sh_cd_sec = val[15:0];
      REG_PSTART: sh_perm_start = {3'b0, val};
      REG_PWIN:   sh_pre_win = val[19:0];
      REG_PSTEP:  sh_pre_step = val[19:0];
      REG_TSTEP:  sh_up_step = val[19:0];
      default: ;
    endcase
  endfunction

  // Advance the shadow timer by one transaction and return its result
  function automatic out_item_t timer_step(in_item_t it);
    out_item_t r;
    logic [31:0] factor, du;
    logic [63:0] prod;
    longint v, d, w, pw, ps, ts;
    int a;
    bit ns;
    r = '0;
    factor = '0;
    case (it.mode)
      MODE_TICK: begin
        if (it.run_present) begin
          if (is_prop_kind()) begin
            a = (it.run_level < 0) ? -int'(it.run_level) : int'(it.run_level);
            factor = 32'(a * 100 / FULL_SCALE);
            if (factor > 100) factor = 100;
          end else begin
            ns = over_threshold(it.run_level);
            if (ns != sh_running) begin
              if (ns) sh_stamp = it.now_ms;
              sh_running = ns;
            end
          end
        end
        if (sh_running) begin
          du = it.now_ms - sh_stamp;
          if (is_prop_kind()) begin
            prod = 64'(du) * 64'(factor);
            du = prod[31:0] / 32'd100;
          end
          if (sh_kind == KIND_PERM) begin
            sh_count = sh_count + du;
            if ($signed(sh_count) >= $signed(PERM_WRAP)) sh_count = '0;
            sh_perm_start = sh_count;
          end else if (sh_kind == KIND_SW || sh_kind == KIND_PSW) begin
            sh_count = sh_count + du;
          end else begin
            v = longint'($signed(sh_count));
            d = longint'($signed(du));
            pw = longint'(sh_pre_win);
            ps = longint'(sh_pre_step);
            ts = longint'(sh_up_step);
            if (pw != 0 && ps != 0 && v > ps && v < pw + 1000) begin
              w = (v / ps) * ps;
              if (v > w && v - d <= w) r.prealert_beep = 1'b1;
            end
            if (v < 0 && ts != 0) begin
              w = ((v - ts) / ts) * ts;
              if (v > w && v - d <= w) r.alarm_beep = 1'b1;
            end
            if (v >= 0 && v < d) r.alarm_beep = 1'b1;
            sh_count = sh_count - du;
          end
          sh_stamp = it.now_ms;
        end
        if (it.reset_present && over_threshold(it.reset_level))
          apply_timer_reset(it.now_ms);
      end
      MODE_TOGGLE: begin
        if (!is_prop_kind()) begin
          sh_running = ~sh_running;
          if (sh_running) sh_stamp = it.now_ms;
        end
      end
      MODE_RESET: apply_timer_reset(it.now_ms);
      default: begin
        if (sh_kind == KIND_PERM) sh_count = it.new_value;
      end
    endcase
    r.value_ms = sh_count;
    r.running = sh_running;
    return r;
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_item(in_item_t it, out_item_t exp_r);
    while (!calm && $urandom_range(99) < 24) @(negedge clk);
    timer_results.push_back(exp_r);
    in_item = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [28:0] val);
    cfg_idx = idx;
    cfg_data = val;
    cfg_we = 1'b1;
    write_shadow_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (timer_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_level();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(1000) - 9500);
      2: return 16'($urandom_range(10000));
      3: return 16'(-int'($urandom_range(10000)));
      4: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(12000) - 2000);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it.mode = (sel < 80) ? MODE_TICK : (sel < 87) ? MODE_TOGGLE :
              (sel < 92) ? MODE_RESET : MODE_SET;
    if ($urandom_range(99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(1500);
    it.now_ms = clock_ms;
    it.run_present = ($urandom_range(9) != 0);
    it.run_level = pick_level();
    it.reset_present = $urandom_range(1);
    it.reset_level = ($urandom_range(99) < 6) ? pick_level() :
                     16'(-int'($urandom_range(32768, 9001)));
    case ($urandom_range(3))
      0: it.new_value = $urandom;
      1: it.new_value = PERM_WRAP - $urandom_range(3000);
      default: it.new_value = $urandom_range(PERM_WRAP + 1000);
    endcase
    return it;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] mode, logic [31:0] now, logic rp,
                                       logic signed [15:0] rl, logic xp,
                                       logic signed [15:0] xl, logic signed [31:0] nv);
    in_item_t it;
    it.mode = mode; it.now_ms = now;
    it.run_present = rp; it.run_level = rl;
    it.reset_present = xp; it.reset_level = xl;
    it.new_value = nv;
    return it;
  endfunction

  typedef struct {
    in_item_t          it;
    bit                typed;
    logic signed [31:0] value;
    logic              running;
  } stim_row_t;

  stim_row_t stim_table[$];

  function automatic void add_row(in_item_t it, bit typed, logic signed [31:0] value,
                                  logic running);
    stim_row_t row;
    row.it = it; row.typed = typed; row.value = value; row.running = running;
    stim_table.push_back(row);
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (timer_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        e = timer_results.pop_front();
        if (out_item.value_ms !== e.value_ms || out_item.running !== e.running ||
            out_item.prealert_beep !== e.prealert_beep ||
            out_item.alarm_beep !== e.alarm_beep) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", e, out_item);
        end
      end
    end
  end

  // Drive the receiver: random stalls, one long hold-off
  always @(negedge clk) begin
    if (hold_out) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 24);
  end

  initial begin
    wait (sent == 400);
    hold_out = 1'b1;
    repeat (600) @(negedge clk);
    hold_out = 1'b0;
  end

  // Watchdog on stalled handshakes
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [2:0] kinds[$];
    logic [2:0] k;
    logic [28:0] perm_val;
    int phase;
    int n;
    in_item_t it;
    out_item_t r;

    sh_kind = KIND_SW; sh_cd_sec = '0; sh_perm_start = '0;
    sh_pre_win = '0; sh_pre_step = '0; sh_up_step = '0;
    sh_running = 1'b0; sh_count = '0; sh_stamp = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows under the reset configuration
    add_row(mk_item(MODE_TICK, 32'd0, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk_item(MODE_TOGGLE, 32'd100, 0, 0, 0, 0, 0), 1, 0, 1);
    add_row(mk_item(MODE_TICK, 32'd350, 0, 0, 0, 0, 0), 1, 250, 1);
    add_row(mk_item(MODE_SET, 32'd360, 0, 0, 0, 0, 32'sh7fffffff), 1, 250, 1);
    add_row(mk_item(MODE_RESET, 32'd400, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk_item(MODE_TICK, 32'd500, 1, 16'sh8000, 0, 0, 0), 1, 0, 0);
    add_row(mk_item(MODE_TICK, 32'd600, 1, -16'sd9000, 0, 0, 0), 1, 0, 0);
    add_row(mk_item(MODE_TICK, 32'hffffffff, 1, -16'sd8999, 0, 0, 0), 1, 0, 1);
    add_row(mk_item(MODE_TICK, 32'd0, 1, 16'sh7fff, 0, 0, 0), 1, 1, 1);
    add_row(mk_item(MODE_TICK, 32'd1000, 1, 16'sh7fff, 1, -16'sd9000, 0), 1, 1001, 1);
    add_row(mk_item(MODE_TICK, 32'd1500, 1, 16'sh7fff, 1, 16'sh7fff, 0), 1, 0, 0);
    add_row(mk_item(MODE_SET, 32'd1600, 1, 16'sh7fff, 1, 16'sh7fff, 32'sh80000000),
            1, 0, 0);
    add_row(mk_item(MODE_TOGGLE, 32'd2000, 0, 0, 0, 0, 0), 1, 0, 1);
    add_row(mk_item(MODE_TOGGLE, 32'd2600, 0, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk_item(MODE_TICK, 32'd3000, 0, 0, 1, 16'sh8000, 32'hffffffff), 1, 0, 0);
    add_row(mk_item(MODE_TICK, 32'd3100, 1, 16'sd5000, 1, -16'sd8999, 0), 0, 0, 0);
    add_row(mk_item(MODE_TICK, 32'h7fffffff, 1, 16'sd5000, 0, 0, 0), 0, 0, 0);
    add_row(mk_item(MODE_TICK, 32'h80000000, 1, -16'sd1, 0, 0, 0), 0, 0, 0);

    foreach (stim_table[i]) begin
      r = timer_step(stim_table[i].it);
      if (stim_table[i].typed) begin
        r.value_ms = stim_table[i].value;
        r.running = stim_table[i].running;
      end
      send_item(stim_table[i].it, r);
    end

    // Random phases, each under a fresh configuration
    kinds = '{KIND_SW, KIND_CD, KIND_PSW, KIND_PCD, KIND_PERM, 3'd5, KIND_CD,
              KIND_PCD, KIND_PERM, 3'd7, KIND_CD, KIND_SW, KIND_PCD, KIND_PERM,
              3'd6, KIND_CD, KIND_PSW, KIND_CD};
    phase = 0;
    while (sent < N_ITEMS) begin
      wait_drained();
      k = kinds[phase % kinds.size()];
      write_reg(REG_KIND, {26'b0, k});
      if (phase == 1) begin
        write_reg(REG_CDSEC, 29'hffff);
        write_reg(REG_PWIN, 29'hfffff);
        write_reg(REG_PSTEP, 29'hfffff);
        write_reg(REG_TSTEP, 29'hfffff);
      end else if (phase == 3) begin
        write_reg(REG_CDSEC, '0);
        write_reg(REG_PWIN, '0);
        write_reg(REG_PSTEP, '0);
        write_reg(REG_TSTEP, '0);
      end else begin
        write_reg(REG_CDSEC, 29'($urandom_range(40)));
        write_reg(REG_PWIN, 29'($urandom_range(4) == 0 ? 0 : $urandom_range(30000)));
        write_reg(REG_PSTEP, 29'($urandom_range(4) == 0 ? 0 : $urandom_range(5000)));
        write_reg(REG_TSTEP, 29'($urandom_range(4) == 0 ? 0 : $urandom_range(5000)));
      end
      case (phase % 4)
        0: perm_val = 29'd359999899;
        1: perm_val = 29'h1fffffff;
        2: perm_val = '0;
        default: perm_val = 29'(359999899 - $urandom_range(20000));
      endcase
      write_reg(REG_PSTART, perm_val);

      // Reset after configuring, as the host does
      it = random_item();
      it.mode = MODE_RESET;
      r = timer_step(it);
      send_item(it, r);

      calm = (phase == 8);
      n = 100;
      while (n > 0 && sent < N_ITEMS) begin
        it = random_item();
        r = timer_step(it);
        send_item(it, r);
        n--;
      end
      calm = 1'b0;
      phase++;
    end

    while (timer_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && timer_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
